// ===== design/frwf_pkg.sv =====
package frwf_pkg;

	localparam int SCALE_FRAC_BITS = 16;

	localparam int KEY_W = 14;
	localparam int MELODIC_CH = 9;
	localparam int RHYTHM_KEYS = 5;
	localparam int FNUM_W = 10;
	localparam int SCALE_W = 18;
	localparam int PROD_W = FNUM_W + SCALE_W;
	localparam int CH_W = 4;
	localparam int STEP_W = 2;

	localparam logic [7:0] REG_FNUM_LO = 8'ha0;
	localparam logic [7:0] REG_KEY_ON = 8'hb0;
	localparam logic [7:0] REG_RHYTHM = 8'hbd;
	localparam int KEY_ON_BIT = 5;

	localparam logic REQ_BUS_WRITE = 1'b0;
	localparam logic REQ_TAKE = 1'b1;
	localparam logic PORT_ADDR = 1'b0;
	localparam logic PORT_DATA = 1'b1;

	localparam logic [STEP_W-1:0] STEP_FIRST = 2'd0;
	localparam logic [STEP_W-1:0] STEP_ADDR = 2'd1;
	localparam logic [STEP_W-1:0] STEP_SECOND = 2'd2;

	typedef enum logic {
		CFG_UNMUTED_MASK = 1'b0,
		CFG_FNUM_SCALE = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		CMD_TAKE = 3'd0,
		CMD_MUTED = 3'd1,
		CMD_PLAIN = 3'd2,
		CMD_KEYON_CONV = 3'd3,
		CMD_FNUM_CONV = 3'd4
	} cmd_kind_t;

	typedef struct packed {
		logic req_type;
		logic port;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic write_valid;
		logic out_port;
		logic [7:0] out_value;
		logic [KEY_W-1:0] key_on_mask;
		logic [KEY_W-1:0] trigger_mask;
		logic last;
	} result_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic port;
		logic [7:0] value;
		logic [CH_W-1:0] ch;
		logic [FNUM_W-1:0] tenbit;
		logic [7:0] rh;
		logic [KEY_W-1:0] key_on;
		logic [KEY_W-1:0] trig;
	} cmd_t;

endpackage

// ===== design/fm_register_write_filter_unit.sv =====
// Register-write filter for an FM sound chip. Bus writes and take-trigger
// requests enter as items through push/full; an item is taken when push is
// high and full is low. Results leave through empty/pop: the oldest result
// sits on the result port while empty is low and is taken when pop is high.
// Each item yields one result, or three when a frequency rescale also has to
// rewrite the partner register; the last flag marks an item's final result.
// The configuration channel (cfg_valid/cfg_ready, always ready) writes the
// unmuted channel mask at index 0 and the frequency scale at index 1; write
// it only while no item is in flight.
// An item passes through the two-entry command queue and the back's command
// register before its first result is loaded into the single output register.
// The front takes one item per cycle while the queue is not full; the back
// emits one result per cycle while the output register can load, and takes
// the next command in the same cycle as it emits the last result of an item.
// When pop stays low, the output register holds, the back stalls, the queue
// fills and full rises. Reset clears the shadow registers, key-on and trigger
// masks and stored rescaled frequencies, and returns the mask to all ones and
// the scale to zero; the queue starts empty, so full is low after reset.
module fm_register_write_filter_unit (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input frwf_pkg::req_t req,
	output logic empty,
	input logic pop,
	output frwf_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [frwf_pkg::SCALE_W-1:0] cfg_data
);

	logic [frwf_pkg::KEY_W-1:0] unmuted_q;
	logic [frwf_pkg::SCALE_W-1:0] scale_q;
	logic scale_on;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_avail;
	frwf_pkg::cmd_t cmd_front;
	frwf_pkg::cmd_t cmd_head;

	assign cfg_ready = 1'b1;
	assign scale_on = (scale_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unmuted_q <= '1;
			scale_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				frwf_pkg::CFG_UNMUTED_MASK: unmuted_q <= cfg_data[frwf_pkg::KEY_W-1:0];
				frwf_pkg::CFG_FNUM_SCALE: scale_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	frwf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.unmuted_mask(unmuted_q),
		.scale_on(scale_on),
		.cmd_push(cmd_push),
		.cmd(cmd_front),
		.cmd_full(cmd_full)
	);

	frwf_cmd_fifo u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.cmd_in(cmd_front),
		.full(cmd_full),
		.pop(cmd_pop),
		.cmd_out(cmd_head),
		.avail(cmd_avail)
	);

	frwf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_avail(cmd_avail),
		.cmd_head(cmd_head),
		.cmd_pop(cmd_pop),
		.fnum_scale(scale_q),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule

// ===== design/frwf_front.sv =====
module frwf_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input frwf_pkg::req_t req,
	input logic [frwf_pkg::KEY_W-1:0] unmuted_mask,
	input logic scale_on,
	output logic cmd_push,
	output frwf_pkg::cmd_t cmd,
	input logic cmd_full
);

	logic accept;
	logic [7:0] reg_index_q;
	logic [7:0] shadow_a_q [frwf_pkg::MELODIC_CH];
	logic [7:0] shadow_b_q [frwf_pkg::MELODIC_CH];
	logic [frwf_pkg::KEY_W-1:0] keyed_on_q;
	logic [frwf_pkg::KEY_W-1:0] triggers_q;
	logic [frwf_pkg::KEY_W-1:0] keyed_next;
	logic [frwf_pkg::KEY_W-1:0] trig_next;
	logic [frwf_pkg::CH_W-1:0] ch;
	logic ch_ok;
	logic is_a;
	logic is_b;
	logic is_rhythm;
	logic is_data;

	assign accept = push && !cmd_full;
	assign full = cmd_full;
	assign cmd_push = accept;

	assign ch_ok = (reg_index_q[3:0] < frwf_pkg::CH_W'(frwf_pkg::MELODIC_CH));
	assign ch = ch_ok ? reg_index_q[3:0] : '0;
	assign is_a = ch_ok && (reg_index_q[7:4] == frwf_pkg::REG_FNUM_LO[7:4]);
	assign is_b = ch_ok && (reg_index_q[7:4] == frwf_pkg::REG_KEY_ON[7:4]);
	assign is_rhythm = (reg_index_q == frwf_pkg::REG_RHYTHM);
	assign is_data = (req.req_type == frwf_pkg::REQ_BUS_WRITE)
		&& (req.port == frwf_pkg::PORT_DATA);

	always_comb begin
		keyed_next = keyed_on_q;
		trig_next = triggers_q;
		cmd.kind = frwf_pkg::CMD_PLAIN;
		cmd.port = req.port;
		cmd.value = req.value;
		cmd.ch = ch;
		cmd.tenbit = '0;
		cmd.rh = '0;
		cmd.trig = '0;
		if (req.req_type == frwf_pkg::REQ_TAKE) begin
			cmd.kind = frwf_pkg::CMD_TAKE;
			cmd.trig = triggers_q;
			trig_next = '0;
		end else if (req.port == frwf_pkg::PORT_DATA) begin
			if (is_b) begin
				if (req.value[frwf_pkg::KEY_ON_BIT]) begin
					if (unmuted_mask[ch]) begin
						keyed_next[ch] = 1'b1;
						trig_next[ch] = 1'b1;
					end else begin
						cmd.kind = frwf_pkg::CMD_MUTED;
					end
				end else begin
					keyed_next[ch] = 1'b0;
				end
				if (cmd.kind != frwf_pkg::CMD_MUTED && scale_on) begin
					cmd.kind = frwf_pkg::CMD_KEYON_CONV;
					cmd.tenbit = {req.value[1:0], shadow_a_q[ch]};
				end
			end else if (is_a) begin
				if (scale_on && unmuted_mask[ch]) begin
					cmd.kind = frwf_pkg::CMD_FNUM_CONV;
					cmd.tenbit = {shadow_b_q[ch][1:0], req.value};
					cmd.rh = shadow_b_q[ch];
				end
			end else if (is_rhythm) begin
				// A muted rhythm key is stripped from the byte sent downstream.
				for (int i = 0; i < frwf_pkg::RHYTHM_KEYS; i++) begin
					if (req.value[i]) begin
						if (unmuted_mask[frwf_pkg::MELODIC_CH + i]) begin
							keyed_next[frwf_pkg::MELODIC_CH + i] = 1'b1;
							trig_next[frwf_pkg::MELODIC_CH + i] = 1'b1;
						end else begin
							cmd.value[i] = 1'b0;
						end
					end
				end
			end
		end
		cmd.key_on = keyed_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_index_q <= '0;
			keyed_on_q <= '0;
			triggers_q <= '0;
			for (int i = 0; i < frwf_pkg::MELODIC_CH; i++) begin
				shadow_a_q[i] <= '0;
				shadow_b_q[i] <= '0;
			end
		end else if (accept) begin
			keyed_on_q <= keyed_next;
			triggers_q <= trig_next;
			if (req.req_type == frwf_pkg::REQ_BUS_WRITE && req.port == frwf_pkg::PORT_ADDR) begin
				reg_index_q <= req.value;
			end
			if (is_data && is_a) begin
				shadow_a_q[ch] <= req.value;
			end
			if (is_data && is_b) begin
				shadow_b_q[ch] <= req.value;
			end
		end
	end

endmodule

// ===== design/frwf_cmd_fifo.sv =====
module frwf_cmd_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input frwf_pkg::cmd_t cmd_in,
	output logic full,
	input logic pop,
	output frwf_pkg::cmd_t cmd_out,
	output logic avail
);

	frwf_pkg::cmd_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == 2'd2);
	assign avail = (count_q != 2'd0);
	assign do_push = push && !full;
	assign do_pop = pop && avail;
	assign cmd_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== design/frwf_back.sv =====
module frwf_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_avail,
	input frwf_pkg::cmd_t cmd_head,
	output logic cmd_pop,
	input logic [frwf_pkg::SCALE_W-1:0] fnum_scale,
	output logic empty,
	input logic pop,
	output frwf_pkg::result_t result
);

	logic [frwf_pkg::PROD_W-1:0] prod;
	logic [frwf_pkg::PROD_W-1:0] prod_shifted;
	logic valid_s1;
	frwf_pkg::cmd_t cmd_s1;
	logic [frwf_pkg::FNUM_W-1:0] fn_s1;
	logic [frwf_pkg::STEP_W-1:0] step_q;
	logic [frwf_pkg::FNUM_W-1:0] conv_q [frwf_pkg::MELODIC_CH];
	logic [frwf_pkg::FNUM_W-1:0] conv_old;
	logic differs;
	logic out_valid_q;
	frwf_pkg::result_t result_q;
	frwf_pkg::result_t res;
	logic out_load;
	logic emit;
	logic finish;
	logic is_conv;

	assign prod = frwf_pkg::PROD_W'(cmd_head.tenbit) * frwf_pkg::PROD_W'(fnum_scale);
	assign prod_shifted = prod >> frwf_pkg::SCALE_FRAC_BITS;

	assign conv_old = conv_q[cmd_s1.ch];
	assign is_conv = (cmd_s1.kind == frwf_pkg::CMD_KEYON_CONV)
		|| (cmd_s1.kind == frwf_pkg::CMD_FNUM_CONV);

	always_comb begin
		res.write_valid = 1'b1;
		res.out_port = frwf_pkg::PORT_DATA;
		res.out_value = cmd_s1.value;
		res.key_on_mask = cmd_s1.key_on;
		res.trigger_mask = '0;
		res.last = 1'b1;
		differs = 1'b0;
		case (cmd_s1.kind)
			frwf_pkg::CMD_TAKE: begin
				res.write_valid = 1'b0;
				res.out_port = frwf_pkg::PORT_ADDR;
				res.out_value = '0;
				res.trigger_mask = cmd_s1.trig;
			end
			frwf_pkg::CMD_PLAIN: begin
				res.out_port = cmd_s1.port;
			end
			frwf_pkg::CMD_KEYON_CONV: begin
				// The low byte moved: rewrite the partner low-byte register too.
				differs = (fn_s1[7:0] != conv_old[7:0]);
				case (step_q)
					frwf_pkg::STEP_FIRST: begin
						res.out_value = {cmd_s1.value[7:2], fn_s1[9:8]};
						res.last = !differs;
					end
					frwf_pkg::STEP_ADDR: begin
						res.out_port = frwf_pkg::PORT_ADDR;
						res.out_value = frwf_pkg::REG_FNUM_LO | 8'(cmd_s1.ch);
						res.last = 1'b0;
					end
					default: begin
						res.out_value = fn_s1[7:0];
					end
				endcase
			end
			frwf_pkg::CMD_FNUM_CONV: begin
				// The high bits moved: rewrite the partner key-on register too.
				differs = (fn_s1[9:8] != conv_old[9:8]);
				case (step_q)
					frwf_pkg::STEP_FIRST: begin
						res.out_value = fn_s1[7:0];
						res.last = !differs;
					end
					frwf_pkg::STEP_ADDR: begin
						res.out_port = frwf_pkg::PORT_ADDR;
						res.out_value = frwf_pkg::REG_KEY_ON | 8'(cmd_s1.ch);
						res.last = 1'b0;
					end
					default: begin
						res.out_value = {cmd_s1.rh[7:2], fn_s1[9:8]};
					end
				endcase
			end
			default: begin
				res.write_valid = 1'b0;
				res.out_port = frwf_pkg::PORT_ADDR;
				res.out_value = '0;
			end
		endcase
	end

	assign out_load = !out_valid_q || pop;
	assign emit = valid_s1 && out_load;
	assign finish = emit && res.last;
	assign cmd_pop = cmd_avail && (!valid_s1 || finish);
	assign empty = !out_valid_q;
	assign result = result_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1 <= cmd_head;
			fn_s1 <= prod_shifted[frwf_pkg::FNUM_W-1:0];
		end
		if (emit) begin
			result_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			step_q <= frwf_pkg::STEP_FIRST;
			out_valid_q <= 1'b0;
			for (int i = 0; i < frwf_pkg::MELODIC_CH; i++) begin
				conv_q[i] <= '0;
			end
		end else begin
			if (cmd_pop) begin
				valid_s1 <= 1'b1;
			end else if (finish) begin
				valid_s1 <= 1'b0;
			end
			if (finish) begin
				step_q <= frwf_pkg::STEP_FIRST;
			end else if (emit) begin
				step_q <= step_q + frwf_pkg::STEP_W'(1);
			end
			if (finish && is_conv) begin
				conv_q[cmd_s1.ch] <= fn_s1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
